// ===== hw/rtl/rpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// rpfm_pkg
// Shared types, constants and codes of the RGB pixel filter with mirror mode.
// ----------------------------------------------------------------------------
package rpfm_pkg;

   // Row geometry and row store layout (two banks of MAX_WIDTH words).
   localparam int MAX_WIDTH     = 1024;
   localparam int COL_W         = $clog2(MAX_WIDTH);
   localparam int WID_W         = $clog2(MAX_WIDTH + 1);
   localparam int ROW_WIDTH_W   = 11;
   localparam int MODE_W        = 3;
   localparam int CMP_W         = (WID_W > ROW_WIDTH_W) ? WID_W : ROW_WIDTH_W;
   localparam int STORE_DEPTH   = 2 * MAX_WIDTH;
   localparam int STORE_ADDR_W  = $clog2(STORE_DEPTH);
   localparam int PIX_W         = 24;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // Queue between the front and the back part.
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   // Arithmetic constants: sums of weighted channels stay below 2^19.
   localparam int SUM_W         = 19;
   localparam int GREY_MUL      = 683;
   localparam int GREY_SHIFT    = 11;
   localparam int DIV1K_MUL     = 268436;
   localparam int DIV1K_SHIFT   = 28;
   localparam int SEPIA_SAT     = 256000;

   typedef logic [COL_W-1:0]        col_type;
   typedef logic [WID_W-1:0]        wid_type;
   typedef logic [CMP_W-1:0]        cmp_type;
   typedef logic [STORE_ADDR_W-1:0] addr_type;
   typedef logic [QPTR_W-1:0]       qptr_type;
   typedef logic [QCNT_W-1:0]       qcnt_type;
   typedef logic [SUM_W-1:0]        sum_type;
   typedef logic [7:0]              chan_type;
   typedef logic [9:0]              coef_type;
   typedef logic [2*SUM_W-1:0]      prod_type;
   typedef logic [20:0]             grey_prod_type;

   // Sepia weights, one row per output channel: red, green, blue inputs.
   localparam coef_type SEPIA_K [3][3] = '{
      '{10'd393, 10'd769, 10'd189},
      '{10'd349, 10'd686, 10'd168},
      '{10'd272, 10'd534, 10'd131}
   };

   typedef enum logic [MODE_W-1:0] {
      MODE_PASS   = 3'd0,
      MODE_INVERT = 3'd1,
      MODE_GREY   = 3'd2,
      MODE_SEPIA  = 3'd3,
      MODE_MIRROR = 3'd4
   } mode_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_DRAIN = 1'b1
   } kind_type;

   typedef enum logic {
      REG_MODE      = 1'b0,
      REG_ROW_WIDTH = 1'b1
   } reg_index_type;

   // Operation the back part applies to a queued pixel.
   typedef enum logic [1:0] {
      OP_COPY   = 2'd0,
      OP_INVERT = 2'd1,
      OP_GREY   = 2'd2,
      OP_SEPIA  = 2'd3
   } op_type;

   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } pix_type;

   typedef struct packed {
      op_type  op;
      pix_type pix;
      logic    last;
   } job_type;

   // Row store address of a column in a bank.
   function automatic addr_type store_addr(input logic bank, input col_type col);
      addr_type base;
      base = bank ? addr_type'(MAX_WIDTH) : '0;
      return base + addr_type'(col);
   endfunction

endpackage

// ===== hw/rtl/rgb_pixel_filter_mirror.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_filter_mirror
// RGB pixel filter: pass, invert, grey, sepia or horizontal row mirror.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream one pixel per beat in raster order;
// req_tuser marks a drain request that flushes the pending mirrored row.
// Results leave on the rsp_ stream, with rsp_tlast marking the last pixel
// of a row. The csr_ port sets the mode (address 0) and the row width
// (address 4); the user writes it only while the stream is idle, as the
// block itself does not enforce this. A request passes through the row
// store read, the queue, the weighted sums and the division into the
// output register. One request is taken every cycle while the queue takes
// the front's jobs; the single read port of the row store serves one mirrored pixel
// per request. In mirror mode the first row gives no results and each
// later pixel or drain request gives one pixel of the previous row,
// reversed. Reset clears the registers and the row state; the row store
// needs no clearing. When the receiver stalls, the output register holds
// its result, the four-entry queue fills, and only then does req_tready drop.
// ----------------------------------------------------------------------------
module rgb_pixel_filter_mirror (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,  // red_in, green_in, blue_in
   input  logic                            req_tuser,  // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,  // red_out, green_out, blue_out
   output logic                            rsp_tlast,  // row_end
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rpfm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rpfm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rpfm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic              front_valid;
   logic              front_ready;
   rpfm_pkg::job_type front_job;
   logic              back_valid;
   logic              back_pop;
   rpfm_pkg::job_type back_job;

   // Front part: classification, row state and row store.
   rpfm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .job_valid   (front_valid),
      .job         (front_job),
      .job_ready   (front_ready)
   );

   // Job queue between the two parts.
   rpfm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (back_valid),
      .pop        (back_pop),
      .pop_job    (back_job)
   );

   // Back part: arithmetic and output register.
   rpfm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (back_valid),
      .job        (back_job),
      .job_pop    (back_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/rpfm_ram.sv =====
// ----------------------------------------------------------------------------
// rpfm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpfm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rpfm_front.sv =====
// ----------------------------------------------------------------------------
// rpfm_front
// Accepts requests, holds the configuration registers and the row state,
// drives the row store and hands one job per result to the queue.
// ----------------------------------------------------------------------------
module rpfm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // red, green, blue
   input  logic                                 req_tuser,  // kind
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rpfm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rpfm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rpfm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output logic                                 job_valid,
   output rpfm_pkg::job_type                    job,
   input  logic                                 job_ready
);

   // Configuration registers.
   logic [rpfm_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [rpfm_pkg::ROW_WIDTH_W-1:0] row_width_ff, row_width_in;

   // Row state.
   rpfm_pkg::col_type write_column_ff, write_column_in;
   rpfm_pkg::col_type read_column_ff, read_column_in;
   logic              write_bank_ff, write_bank_in;
   logic              row_pending_ff, row_pending_in;

   // Stage that waits for the row store read data.
   logic              s1_valid_ff, s1_valid_in;
   rpfm_pkg::op_type  s1_op_ff, s1_op_in;
   rpfm_pkg::pix_type s1_pix_ff, s1_pix_in;
   logic              s1_last_ff, s1_last_in;
   logic              s1_store_ff, s1_store_in;

   logic               csr_write;
   logic               accept;
   logic               s1_go;
   rpfm_pkg::cmp_type  rw_cmp;
   rpfm_pkg::wid_type  w;
   rpfm_pkg::wid_type  rd_cnt;
   logic               rd_in_range;
   logic               rd_last;
   logic               emit_ok;
   rpfm_pkg::col_type  rd_col;
   rpfm_pkg::col_type  wc;
   logic               wc_last;
   rpfm_pkg::col_type  wc_next;
   rpfm_pkg::pix_type  req_pix;
   logic               st_wr_en;
   logic               st_rd_en;
   rpfm_pkg::addr_type st_wr_addr;
   rpfm_pkg::addr_type st_rd_addr;
   rpfm_pkg::pix_type  st_rd_data;

   assign req_pix = rpfm_pkg::pix_type'(req_tdata);

   // Configuration port: writes at the access phase, reads straight from the registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in      = mode_ff;
      row_width_in = row_width_ff;
      if (csr_write) begin
         unique case (rpfm_pkg::reg_index_type'(csr_paddr[2]))
            rpfm_pkg::REG_MODE:      mode_in      = csr_pwdata[rpfm_pkg::MODE_W-1:0];
            rpfm_pkg::REG_ROW_WIDTH: row_width_in = csr_pwdata[rpfm_pkg::ROW_WIDTH_W-1:0];
            default:                 mode_in      = mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (rpfm_pkg::reg_index_type'(csr_paddr[2]))
         rpfm_pkg::REG_MODE:
            csr_prdata = rpfm_pkg::CSR_DATA_W'(mode_ff);
         rpfm_pkg::REG_ROW_WIDTH:
            csr_prdata = rpfm_pkg::CSR_DATA_W'(row_width_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // Width in use: row_width clamped to 1..MAX_WIDTH.
   always_comb begin
      rw_cmp = rpfm_pkg::cmp_type'(row_width_ff);
      if (row_width_ff == '0) begin
         w = rpfm_pkg::wid_type'(1);
      end else if (rw_cmp > rpfm_pkg::cmp_type'(rpfm_pkg::MAX_WIDTH)) begin
         w = rpfm_pkg::wid_type'(rpfm_pkg::MAX_WIDTH);
      end else begin
         w = rpfm_pkg::wid_type'(row_width_ff);
      end
   end

   // Read side of the pending mirrored row: next column, counted from the end.
   assign rd_cnt      = rpfm_pkg::wid_type'(read_column_ff);
   assign rd_in_range = rd_cnt < w;
   assign rd_last     = rd_cnt == (w - rpfm_pkg::wid_type'(1));
   assign emit_ok     = row_pending_ff && rd_in_range;
   assign rd_col      = rpfm_pkg::col_type'(w - rpfm_pkg::wid_type'(1) - rd_cnt);

   // Write side: a column beyond a shrunk width restarts the row.
   assign wc      = (rpfm_pkg::wid_type'(write_column_ff) >= w) ? '0 : write_column_ff;
   assign wc_last = rpfm_pkg::wid_type'(wc) == (w - rpfm_pkg::wid_type'(1));
   assign wc_next = wc_last ? '0 : wc + rpfm_pkg::col_type'(1);

   // The stage moves on when it is empty or the queue takes its job.
   assign s1_go      = !s1_valid_ff || job_ready;
   assign req_tready = s1_go;
   assign accept     = req_tvalid && req_tready;

   assign st_wr_addr = rpfm_pkg::store_addr(write_bank_ff, wc);
   assign st_rd_addr = rpfm_pkg::store_addr(!write_bank_ff, rd_col);

   // Classify the request and update the row state.
   always_comb begin
      write_column_in = write_column_ff;
      read_column_in  = read_column_ff;
      write_bank_in   = write_bank_ff;
      row_pending_in  = row_pending_ff;
      st_wr_en        = 1'b0;
      st_rd_en        = 1'b0;
      s1_valid_in     = s1_go ? 1'b0 : s1_valid_ff;
      s1_op_in        = s1_op_ff;
      s1_pix_in       = s1_pix_ff;
      s1_last_in      = s1_last_ff;
      s1_store_in     = s1_store_ff;
      if (accept) begin
         s1_pix_in = req_pix;
         if (rpfm_pkg::kind_type'(req_tuser) == rpfm_pkg::KIND_DRAIN ||
             mode_ff == rpfm_pkg::MODE_MIRROR) begin
            // Emit the next pixel of the pending row, if there is one.
            s1_valid_in    = emit_ok;
            s1_op_in       = rpfm_pkg::OP_COPY;
            s1_last_in     = rd_last;
            s1_store_in    = 1'b1;
            st_rd_en       = emit_ok;
            row_pending_in = emit_ok && !rd_last;
            if (emit_ok) begin
               read_column_in = read_column_ff + rpfm_pkg::col_type'(1);
            end
            // A mirror pixel goes into the bank being filled.
            if (rpfm_pkg::kind_type'(req_tuser) == rpfm_pkg::KIND_PIXEL) begin
               st_wr_en        = 1'b1;
               write_column_in = wc_next;
               if (wc_last) begin
                  write_bank_in  = !write_bank_ff;
                  row_pending_in = 1'b1;
                  read_column_in = '0;
               end
            end
         end else begin
            // Per-pixel filter: one result for every pixel.
            s1_valid_in     = 1'b1;
            s1_last_in      = wc_last;
            s1_store_in     = 1'b0;
            write_column_in = wc_next;
            unique case (mode_ff)
               rpfm_pkg::MODE_INVERT: s1_op_in = rpfm_pkg::OP_INVERT;
               rpfm_pkg::MODE_GREY:   s1_op_in = rpfm_pkg::OP_GREY;
               rpfm_pkg::MODE_SEPIA:  s1_op_in = rpfm_pkg::OP_SEPIA;
               default:               s1_op_in = rpfm_pkg::OP_COPY;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= rpfm_pkg::MODE_PASS;
         row_width_ff    <= rpfm_pkg::ROW_WIDTH_W'(1024);
         write_column_ff <= '0;
         read_column_ff  <= '0;
         write_bank_ff   <= 1'b0;
         row_pending_ff  <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         row_width_ff    <= row_width_in;
         write_column_ff <= write_column_in;
         read_column_ff  <= read_column_in;
         write_bank_ff   <= write_bank_in;
         row_pending_ff  <= row_pending_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_pix_ff   <= s1_pix_in;
      s1_last_ff  <= s1_last_in;
      s1_store_ff <= s1_store_in;
   end

   // Ping-pong row store.
   rpfm_ram #(
      .WIDTH (rpfm_pkg::PIX_W),
      .DEPTH (rpfm_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (req_pix),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // Job to the queue, with the row store data merged in.
   assign job_valid = s1_valid_ff;
   always_comb begin
      job.op   = s1_op_ff;
      job.pix  = s1_store_ff ? st_rd_data : s1_pix_ff;
      job.last = s1_last_ff;
   end

endmodule

// ===== hw/rtl/rpfm_queue.sv =====
// ----------------------------------------------------------------------------
// rpfm_queue
// Short job queue that lets the front and the back part stall on their own.
// ----------------------------------------------------------------------------
module rpfm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rpfm_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop,
   output rpfm_pkg::job_type pop_job
);

   rpfm_pkg::job_type  slot_ff [rpfm_pkg::QUEUE_DEPTH];
   rpfm_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   rpfm_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   rpfm_pkg::qcnt_type count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff < rpfm_pkg::qcnt_type'(rpfm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_job    = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rpfm_pkg::qptr_type'(rpfm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + rpfm_pkg::qptr_type'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rpfm_pkg::qptr_type'(rpfm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + rpfm_pkg::qptr_type'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + rpfm_pkg::qcnt_type'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - rpfm_pkg::qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/rpfm_back.sv =====
// ----------------------------------------------------------------------------
// rpfm_back
// Carries out the per-pixel operation in two stages and holds the result
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module rpfm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  rpfm_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,  // red_out, green_out, blue_out
   output logic              rsp_tlast   // row_end
);

   // Weighted-sum stage.
   logic              p1_valid_ff, p1_valid_in;
   rpfm_pkg::op_type  p1_op_ff, p1_op_in;
   rpfm_pkg::sum_type p1_sum_ff [3];
   rpfm_pkg::sum_type p1_sum_in [3];
   logic              p1_last_ff, p1_last_in;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   rpfm_pkg::pix_type out_pix_ff, out_pix_in;
   logic              out_last_ff, out_last_in;

   logic                    out_go;
   logic                    p1_go;
   rpfm_pkg::chan_type      chan_in [3];
   rpfm_pkg::chan_type      chan_res [3];
   rpfm_pkg::prod_type      sepia_prod [3];
   rpfm_pkg::grey_prod_type grey_prod;
   rpfm_pkg::chan_type      grey_val;

   // Every stage moves on when the one after it has room.
   assign out_go  = !out_valid_ff || rsp_tready;
   assign p1_go   = !p1_valid_ff || out_go;
   assign job_pop = job_valid && p1_go;

   assign chan_in[0] = job.pix.red;
   assign chan_in[1] = job.pix.green;
   assign chan_in[2] = job.pix.blue;

   // Stage one: channel sums, weighted sums or the finished channel.
   always_comb begin
      p1_valid_in = p1_go ? job_valid : p1_valid_ff;
      p1_op_in    = p1_op_ff;
      p1_last_in  = p1_last_ff;
      for (int i = 0; i < 3; i++) begin
         p1_sum_in[i] = p1_sum_ff[i];
      end
      if (job_pop) begin
         p1_op_in   = job.op;
         p1_last_in = job.last;
         for (int i = 0; i < 3; i++) begin
            unique case (job.op)
               rpfm_pkg::OP_INVERT:
                  p1_sum_in[i] = rpfm_pkg::sum_type'(~chan_in[i]);
               rpfm_pkg::OP_GREY:
                  p1_sum_in[i] = rpfm_pkg::sum_type'(chan_in[0]) +
                                 rpfm_pkg::sum_type'(chan_in[1]) +
                                 rpfm_pkg::sum_type'(chan_in[2]);
               rpfm_pkg::OP_SEPIA:
                  p1_sum_in[i] =
                     rpfm_pkg::sum_type'(rpfm_pkg::SEPIA_K[i][0]) *
                     rpfm_pkg::sum_type'(chan_in[0]) +
                     rpfm_pkg::sum_type'(rpfm_pkg::SEPIA_K[i][1]) *
                     rpfm_pkg::sum_type'(chan_in[1]) +
                     rpfm_pkg::sum_type'(rpfm_pkg::SEPIA_K[i][2]) *
                     rpfm_pkg::sum_type'(chan_in[2]);
               default:
                  p1_sum_in[i] = rpfm_pkg::sum_type'(chan_in[i]);
            endcase
         end
      end
   end

   // Stage two: divide by three or by 1000 through a reciprocal multiply.
   assign grey_prod = rpfm_pkg::grey_prod_type'(p1_sum_ff[0][9:0]) *
                      rpfm_pkg::grey_prod_type'(rpfm_pkg::GREY_MUL);
   assign grey_val  = rpfm_pkg::chan_type'(grey_prod >> rpfm_pkg::GREY_SHIFT);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sepia_prod[i] = rpfm_pkg::prod_type'(p1_sum_ff[i]) *
                         rpfm_pkg::prod_type'(rpfm_pkg::DIV1K_MUL);
         unique case (p1_op_ff)
            rpfm_pkg::OP_GREY:
               chan_res[i] = grey_val;
            rpfm_pkg::OP_SEPIA:
               if (p1_sum_ff[i] >= rpfm_pkg::sum_type'(rpfm_pkg::SEPIA_SAT)) begin
                  chan_res[i] = 8'hFF;
               end else begin
                  chan_res[i] = rpfm_pkg::chan_type'(sepia_prod[i] >> rpfm_pkg::DIV1K_SHIFT);
               end
            default:
               chan_res[i] = p1_sum_ff[i][7:0];
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_go ? p1_valid_ff : out_valid_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      if (out_go && p1_valid_ff) begin
         out_pix_in.red   = chan_res[0];
         out_pix_in.green = chan_res[1];
         out_pix_in.blue  = chan_res[2];
         out_last_in      = p1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_op_ff    <= p1_op_in;
      p1_last_ff  <= p1_last_in;
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
      for (int i = 0; i < 3; i++) begin
         p1_sum_ff[i] <= p1_sum_in[i];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hw/rtl/rpfm_check.sv =====
// ----------------------------------------------------------------------------
// rpfm_check
// Port-level checks of the pixel filter, bound to the top level.
// ----------------------------------------------------------------------------
module rpfm_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [23:0]                     req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [23:0]                     rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [rpfm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [rpfm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [rpfm_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                            csr_pready
);

   logic csr_write;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // A stalled result stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset leaves no result on the output.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A mode write reads back on the next cycle.
   a_mode_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_paddr[2] == 1'b0 |=>
         csr_paddr[2] || csr_prdata[2:0] == $past(csr_pwdata[2:0]))
      else $error("mode read back differs from the write");

   // A row width write reads back on the next cycle.
   a_width_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_paddr[2] == 1'b1 |=>
         !csr_paddr[2] || csr_prdata[10:0] == $past(csr_pwdata[10:0]))
      else $error("row width read back differs from the write");

endmodule

bind rgb_pixel_filter_mirror rpfm_check u_check (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the RGB pixel filter with horizontal mirror.
// ----------------------------------------------------------------------------
// Pixel and drain requests are sent on the req_ stream while an internal
// filter predictor computes each expected result pixel. The first part covers
// every colour mode with extreme pixels, then the widest rows, then the mirror corner
// cases. The last part is random traffic. The random traffic uses many mode and
// width settings and has random idling on both streams. Each result on the
// rsp_ stream is compared field by field with the oldest expected pixel.
// ----------------------------------------------------------------------------
module tb_top;
   import rpfm_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 8;        // result latency plus margin
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RUN_LIMIT_NS  = 2000000;
   localparam int RANDOM_PIXELS = 1000;
   localparam int IDLE_PERCENT  = 7;

   localparam logic [MODE_W-1:0] FIRST_SPARE_MODE = MODE_MIRROR + 1;

   // Probe pixels: all dark, all bright and one with distinct channels.
   localparam pix_type MODE_PROBES [3] = '{24'h000000, 24'hFFFFFF, 24'h3C80C7};

   // Sepia weights in thousandths, one row per output channel.
   localparam int unsigned SEPIA_WEIGHTS [3][3] = '{
      '{393, 769, 189},
      '{349, 686, 168},
      '{272, 534, 131}
   };

   typedef struct packed {
      logic    row_end;
      pix_type pix;
   } out_pixel_t;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata   = '0;   // red_in, green_in, blue_in
   logic                  req_tuser   = 1'b0; // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [23:0]           rsp_tdata;          // red_out, green_out, blue_out
   logic                  rsp_tlast;          // row_end
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Filter predictor state.
   logic [MODE_W-1:0]      flt_mode      = MODE_PASS;
   logic [ROW_WIDTH_W-1:0] flt_row_width = 11'd1024;
   int unsigned            wr_column     = 0;
   int unsigned            rd_column     = 0;
   bit                     wr_bank       = 1'b0;
   bit                     row_waiting   = 1'b0;
   pix_type                row_mem [STORE_DEPTH];

   out_pixel_t  expected_pixels [$];
   int unsigned error_count = 0;
   bit          steady_flow = 1'b0;

   rgb_pixel_filter_mirror i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH at %0t: %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // Either side idles now and then, except during a steady stretch.
   function automatic bit idle_roll();
      return !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   function automatic chan_type random_level();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return chan_type'($urandom_range(255));
   endfunction

   function automatic pix_type random_pixel();
      pix_type p;
      p.red   = random_level();
      p.green = random_level();
      p.blue  = random_level();
      return p;
   endfunction

   // Row width as the block uses it: zero acts as one, large values saturate.
   function automatic int unsigned active_width();
      if (flt_row_width == 0) return 1;
      if (flt_row_width > MAX_WIDTH) return MAX_WIDTH;
      return flt_row_width;
   endfunction

   function automatic chan_type sepia_level(pix_type p, int ch);
      int unsigned level;
      level = (SEPIA_WEIGHTS[ch][0] * p.red + SEPIA_WEIGHTS[ch][1] * p.green +
               SEPIA_WEIGHTS[ch][2] * p.blue) / 1000;
      return (level > 255) ? 8'hFF : chan_type'(level);
   endfunction

   // Emits the next pixel of the pending mirrored row, reading it backwards.
   function automatic void flush_mirror_pixel(int unsigned w);
      out_pixel_t res;
      int unsigned col;
      if (!row_waiting) return;
      if (rd_column >= w) begin
         row_waiting = 1'b0;
         return;
      end
      col = w - 1 - rd_column;
      res.pix = row_mem[(wr_bank ? 0 : MAX_WIDTH) + col];
      res.row_end = (rd_column == w - 1);
      expected_pixels.push_back(res);
      rd_column++;
      if (rd_column >= w) row_waiting = 1'b0;
   endfunction

   // Works out the result pixel, if any, of one accepted request.
   function automatic void predict_filter(kind_type kind, pix_type pix);
      out_pixel_t  res;
      int unsigned w;
      int unsigned level;
      w = active_width();
      if (kind == KIND_DRAIN) begin
         flush_mirror_pixel(w);
         return;
      end
      if (wr_column >= w) wr_column = 0;
      if (flt_mode == MODE_MIRROR) begin
         flush_mirror_pixel(w);
         row_mem[(wr_bank ? MAX_WIDTH : 0) + wr_column] = pix;
         wr_column++;
         if (wr_column >= w) begin
            wr_column   = 0;
            wr_bank     = !wr_bank;
            row_waiting = 1'b1;
            rd_column   = 0;
         end
         return;
      end
      res.row_end = (wr_column == w - 1);
      wr_column++;
      if (wr_column >= w) wr_column = 0;
      case (flt_mode)
         MODE_INVERT: begin
            res.pix.red   = 8'd255 - pix.red;
            res.pix.green = 8'd255 - pix.green;
            res.pix.blue  = 8'd255 - pix.blue;
         end
         MODE_GREY: begin
            level = (pix.red + pix.green + pix.blue) / 3;
            res.pix.red   = chan_type'(level);
            res.pix.green = chan_type'(level);
            res.pix.blue  = chan_type'(level);
         end
         MODE_SEPIA: begin
            res.pix.red   = sepia_level(pix, 0);
            res.pix.green = sepia_level(pix, 1);
            res.pix.blue  = sepia_level(pix, 2);
         end
         default: res.pix = pix;
      endcase
      expected_pixels.push_back(res);
   endfunction

   // Sends one request, with an occasional gap in front of it.
   task automatic send_request(kind_type kind, pix_type pix);
      if (idle_roll()) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      predict_filter(kind, pix);
   endtask

   // Holds off requests until every expected pixel has arrived.
   task automatic wait_all_results();
      int unsigned guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register, then reads it back.
   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] readback;
      mask = (idx == REG_MODE) ? (1 << MODE_W) - 1 : (1 << ROW_WIDTH_W) - 1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_MODE) flt_mode = value[MODE_W-1:0];
      else flt_row_width = value[ROW_WIDTH_W-1:0];
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if ((readback & mask) !== (value & mask))
         report_mismatch("register read back", readback & mask, value & mask);
   endtask

   task automatic set_filter(logic [MODE_W-1:0] mode, logic [ROW_WIDTH_W-1:0] width);
      wait_all_results();
      write_register(REG_MODE, CSR_DATA_W'(mode));
      write_register(REG_ROW_WIDTH, CSR_DATA_W'(width));
   endtask

   // Every colour mode, the spare modes included, on extreme pixels.
   task automatic test_pixel_modes();
      logic [MODE_W-1:0] modes [7];
      modes = '{MODE_PASS, MODE_INVERT, MODE_GREY, MODE_SEPIA, FIRST_SPARE_MODE,
                FIRST_SPARE_MODE + 1, FIRST_SPARE_MODE + 2};
      foreach (modes[m]) begin
         set_filter(modes[m], 11'd3);
         foreach (MODE_PROBES[k]) send_request(KIND_PIXEL, MODE_PROBES[k]);
      end
   endtask

   // Zero width, then full-width mirrored rows that also fill both store banks.
   task automatic test_wide_rows();
      set_filter(MODE_PASS, 11'd0);
      repeat (2) send_request(KIND_PIXEL, random_pixel());
      set_filter(MODE_MIRROR, 11'h7FF);
      repeat (2 * MAX_WIDTH) send_request(KIND_PIXEL, random_pixel());
      repeat (MAX_WIDTH + 1) send_request(KIND_DRAIN, random_pixel());
   endtask

   // Mirror corner cases: flush, overtaken row, width shrink and dropped row.
   task automatic test_mirror_cases();
      set_filter(MODE_MIRROR, 11'd3);
      repeat (6) send_request(KIND_PIXEL, random_pixel());
      repeat (4) send_request(KIND_DRAIN, random_pixel());
      repeat (3) send_request(KIND_PIXEL, random_pixel());
      // Pass pixels move the column but leave the pending row alone.
      set_filter(MODE_PASS, 11'd3);
      repeat (2) send_request(KIND_PIXEL, random_pixel());
      set_filter(MODE_MIRROR, 11'd3);
      send_request(KIND_PIXEL, random_pixel());
      repeat (3) send_request(KIND_DRAIN, random_pixel());
      // Shrink the width while a row is half written.
      set_filter(MODE_PASS, 11'd6);
      repeat (4) send_request(KIND_PIXEL, random_pixel());
      set_filter(MODE_PASS, 11'd3);
      repeat (2) send_request(KIND_PIXEL, random_pixel());
      // Shrink the width under a partly emitted mirrored row.
      set_filter(MODE_MIRROR, 11'd4);
      repeat (8) send_request(KIND_PIXEL, random_pixel());
      repeat (2) send_request(KIND_DRAIN, random_pixel());
      set_filter(MODE_MIRROR, 11'd1);
      repeat (2) send_request(KIND_DRAIN, random_pixel());
   endtask

   // Random settings, mostly whole rows, with stray drains and flushes.
   task automatic test_random_traffic();
      int unsigned            sent;
      int unsigned            phase;
      int unsigned            roll;
      int unsigned            w;
      int unsigned            n;
      logic [MODE_W-1:0]      mode;
      logic [ROW_WIDTH_W-1:0] width;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         steady_flow = (phase >= 8 && phase < 16);
         roll = $urandom_range(99);
         if (roll < 45) mode = MODE_MIRROR;
         else if (roll < 92) mode = MODE_W'($urandom_range(int'(MODE_SEPIA)));
         else mode = FIRST_SPARE_MODE + MODE_W'($urandom_range(2));
         roll = $urandom_range(99);
         if (roll < 70) width = ROW_WIDTH_W'($urandom_range(1, 8));
         else if (roll < 94) width = ROW_WIDTH_W'($urandom_range(9, 40));
         else if (roll < 97) width = '0;
         else width = ROW_WIDTH_W'($urandom_range(MAX_WIDTH, 2047));
         set_filter(mode, width);
         w = active_width();
         n = $urandom_range(1, 4) * w;
         if ($urandom_range(1)) n += $urandom_range(w - 1);
         if (n > 64) n = $urandom_range(16, 64);
         repeat (n) begin
            if ($urandom_range(99) < 5) send_request(KIND_DRAIN, random_pixel());
            send_request(KIND_PIXEL, random_pixel());
            sent++;
         end
         if (mode == MODE_MIRROR && $urandom_range(3) != 0)
            repeat (((w > 64) ? 64 : w) + $urandom_range(2))
               send_request(KIND_DRAIN, random_pixel());
         phase++;
      end
      steady_flow = 1'b0;
   endtask

   // Result checker and receiver stall.
   always @(posedge clock) begin : result_check
      out_pixel_t want;
      pix_type    got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            report_mismatch("result pixel with none expected", got, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (got.red !== want.pix.red)
               report_mismatch("red channel", got.red, want.pix.red);
            if (got.green !== want.pix.green)
               report_mismatch("green channel", got.green, want.pix.green);
            if (got.blue !== want.pix.blue)
               report_mismatch("blue channel", got.blue, want.pix.blue);
            if (rsp_tlast !== want.row_end)
               report_mismatch("row end", rsp_tlast, want.row_end);
         end
      end
      rsp_tready <= !idle_roll();
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_pixel_modes();
      test_wide_rows();
      test_mirror_cases();
      test_random_traffic();
      wait_all_results();
      if (expected_pixels.size() != 0)
         report_mismatch("result pixels never arrived", 0, expected_pixels.size());
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout: the run did not complete");
      $display("Simulation FAILED");
      $finish;
   end

endmodule
